>>> hw/rtl/htlc_pkg.sv
// Shared types and constants for the hall-triggered lever controller.
// Depends on nothing; used by htlc_ring and hall_triggered_lever_controller.

package htlc_pkg;

    localparam int TIME_W    = 32;
    localparam int THRESH_W  = 12;
    localparam int DELAY_W   = 16;
    localparam int GAIN_W    = 17;
    localparam int ANGLE_W   = 8;
    localparam int POS_W     = 24;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HALL_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_ANGLE   = 3'd5;

    // register values after reset
    localparam logic [THRESH_W-1:0] RST_HALL_THRESHOLD = 12'd2600;
    localparam logic [DELAY_W-1:0]  RST_CLOSE_DELAY    = 16'd500;
    localparam logic [DELAY_W-1:0]  RST_OPEN_DELAY     = 16'd10000;
    localparam logic [GAIN_W-1:0]   RST_SMOOTH_GAIN    = 17'd1311;
    localparam logic [ANGLE_W-1:0]  RST_OPEN_ANGLE     = 8'd0;
    localparam logic [ANGLE_W-1:0]  RST_CLOSED_ANGLE   = 8'd90;

    // unity gain in Q16
    localparam logic [GAIN_W-1:0] Q16_ONE = 17'h10000;

    // what travels beside the sample through the averaging stages
    typedef struct packed {
        logic              tick;
        logic [TIME_W-1:0] time_ms;
    } item_t;

endpackage

>>> hw/rtl/htlc_ring.sv
// Sample window of the lever controller: ring memory, running sum and average.
// Depends on htlc_pkg (item_t).

module htlc_ring #(
    parameter int WINDOW_LEN  = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  htlc_pkg::item_t        in_item,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output htlc_pkg::item_t        out_item,
    output logic [SAMPLE_BITS-1:0] out_average
);

    localparam int IDX_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int LOG_W     = $clog2(WINDOW_LEN);
    localparam int SUM_W     = SAMPLE_BITS + LOG_W;
    localparam int DIV_SHIFT = SUM_W + LOG_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW_LEN - 1);
    localparam logic [SUM_W-1:0]   SUM_MAX  =
        SUM_W'(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1));

    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]  live_reg;
    logic [IDX_W-1:0]       wr_idx_reg;
    logic [SUM_W-1:0]       sum_reg;

    logic                   in_load;
    logic                   b_valid_reg;
    htlc_pkg::item_t        b_item_reg;
    logic [SAMPLE_BITS-1:0] b_sample_reg;
    logic [IDX_W-1:0]       b_idx_reg;
    logic [SAMPLE_BITS-1:0] b_rd_reg;
    logic                   b_live_reg;
    logic                   b_fwd_reg;
    logic [SAMPLE_BITS-1:0] b_fwd_data_reg;
    logic                   b_commit;
    logic                   b_write;
    logic                   collide;
    logic [SAMPLE_BITS-1:0] old_entry;
    logic [SUM_W-1:0]       sum_new;

    logic                   c_valid_reg;
    logic                   c_ready;
    htlc_pkg::item_t        c_item_reg;
    logic [SUM_W-1:0]       c_sum_reg;
    logic [PROD_W-1:0]      quot_prod;

    logic                   d_valid_reg;
    logic                   d_ready;
    logic                   d_load;
    htlc_pkg::item_t        d_item_reg;
    logic [SAMPLE_BITS-1:0] d_avg_reg;

    assign in_ready = !b_valid_reg || c_ready;
    assign in_load  = in_valid && in_ready;
    assign b_commit = b_valid_reg && c_ready;
    assign b_write  = b_commit && !b_item_reg.tick;
    // write back and read of the same entry in one edge: take the sample directly
    assign collide  = b_write && (b_idx_reg == wr_idx_reg);

    assign old_entry = b_fwd_reg ? b_fwd_data_reg : (b_live_reg ? b_rd_reg : '0);
    assign sum_new   = sum_reg - SUM_W'(old_entry) + SUM_W'(b_sample_reg);

    assign c_ready   = !c_valid_reg || d_ready;
    assign quot_prod = PROD_W'(c_sum_reg) * PROD_W'(RECIP);

    assign d_ready = !d_valid_reg || out_ready;
    assign d_load  = c_valid_reg && d_ready;

    // ring memory: read at accept, write back when the sum stage commits
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            b_rd_reg <= ring_mem[wr_idx_reg];
        end
        if (b_write)
        begin
            ring_mem[b_idx_reg] <= b_sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            wr_idx_reg  <= '0;
            sum_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load && !in_item.tick)
            begin
                wr_idx_reg <= (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
            end
            if (b_write)
            begin
                live_reg[b_idx_reg] <= 1'b1;
                sum_reg             <= sum_new;
            end
            if (in_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            b_item_reg     <= in_item;
            b_sample_reg   <= in_sample;
            b_idx_reg      <= wr_idx_reg;
            b_live_reg     <= live_reg[wr_idx_reg];
            b_fwd_reg      <= collide;
            b_fwd_data_reg <= b_sample_reg;
        end
        if (b_commit)
        begin
            c_item_reg <= b_item_reg;
            c_sum_reg  <= b_item_reg.tick ? sum_reg : sum_new;
        end
        if (d_load)
        begin
            d_item_reg <= c_item_reg;
            d_avg_reg  <= quot_prod[DIV_SHIFT +: SAMPLE_BITS];
        end
    end

    assign out_valid   = d_valid_reg;
    assign out_item    = d_item_reg;
    assign out_average = d_avg_reg;

    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("running sum beyond a full window of samples");

    a_ring_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= LAST_IDX)
        else $error("ring index beyond the window");

    a_sum_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !b_write |=> $stable(sum_reg))
        else $error("running sum moved without a ring write");

endmodule

>>> hw/rtl/hall_triggered_lever_controller.sv
// Top level of the hall-triggered lever controller: configuration registers,
// contact latch, lever timing and servo smoothing. Depends on htlc_pkg, htlc_ring.

// Usage
// -----
// Input words (valid/ready) carry mode, sample and time_ms. mode 0 is a hall
// sample that enters a window of WINDOW_LEN samples; mode 1 is a millisecond
// tick that runs the contact latch, picks the target angle and moves the
// smoothed servo position one filter step. Every word gives exactly one
// result word (valid/ready) with the state after that word.
// Result valid rises after the input word is accepted and has passed the registers for
// ring read, running sum, average multiply, tick logic and servo filter / output.
// Throughput is one word per cycle while out_ready holds; the window is one ring
// memory with one read and one write port, and back-to-back words to the same
// ring entry are forwarded around it.
// A stalled receiver holds the output register; the stages behind it keep
// filling, and in_ready drops only once every stage holds a word.
// Reset clears the pipeline, the window (each ring entry reads as zero until
// first written), the latch, target and position, and loads the register
// defaults; there is no clearing pass. Configuration writes (cfg_write,
// cfg_index, cfg_data) take effect on the next edge and belong to idle time.

module hall_triggered_lever_controller #(
    parameter int WINDOW_LEN  = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [htlc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [htlc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic [htlc_pkg::TIME_W-1:0]      time_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [SAMPLE_BITS-1:0]           average_level,
    output logic                             latched,
    output logic [htlc_pkg::ANGLE_W-1:0]     target_angle,
    output logic [htlc_pkg::POS_W-1:0]       position_q16,
    output logic [htlc_pkg::ANGLE_W-1:0]     servo_angle
);

    localparam int TIME_W  = htlc_pkg::TIME_W;
    localparam int ANGLE_W = htlc_pkg::ANGLE_W;
    localparam int POS_W   = htlc_pkg::POS_W;
    localparam int FRAC_W  = htlc_pkg::FRAC_W;
    localparam int GAIN_W  = htlc_pkg::GAIN_W;
    localparam int DIFF_W  = POS_W + 1;
    localparam int ACC_W   = POS_W + FRAC_W + 4;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1 << (FRAC_W - 1));

    // configuration registers
    logic [htlc_pkg::THRESH_W-1:0] hall_threshold_reg;
    logic [htlc_pkg::DELAY_W-1:0]  close_delay_reg;
    logic [htlc_pkg::DELAY_W-1:0]  open_delay_reg;
    logic [GAIN_W-1:0]             gain_reg;
    logic [ANGLE_W-1:0]            open_angle_reg;
    logic [ANGLE_W-1:0]            closed_angle_reg;

    htlc_pkg::item_t        in_item;
    logic                   ring_valid;
    logic                   ring_ready;
    htlc_pkg::item_t        ring_item;
    logic [SAMPLE_BITS-1:0] ring_avg;

    // tick stage
    logic                   e_valid_reg;
    logic                   e_ready;
    logic                   e_load;
    logic                   e_tick_reg;
    logic [SAMPLE_BITS-1:0] e_avg_reg;
    logic                   latch_reg;
    logic [TIME_W-1:0]      contact_reg;
    logic [ANGLE_W-1:0]     target_reg;
    logic                   latch_next;
    logic [TIME_W-1:0]      contact_next;
    logic [ANGLE_W-1:0]     target_next;
    logic                   at_contact;
    logic [TIME_W-1:0]      elapsed;

    // filter / output stage
    logic                     f_ready;
    logic                     f_load;
    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   out_avg_reg;
    logic                     out_latched_reg;
    logic [ANGLE_W-1:0]       out_target_reg;
    logic [POS_W-1:0]         position_reg;
    logic [GAIN_W-1:0]        gain_eff;
    logic signed [DIFF_W-1:0] pos_diff;
    logic signed [ACC_W-1:0]  filt_acc;

    // configuration port: unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hall_threshold_reg <= htlc_pkg::RST_HALL_THRESHOLD;
            close_delay_reg    <= htlc_pkg::RST_CLOSE_DELAY;
            open_delay_reg     <= htlc_pkg::RST_OPEN_DELAY;
            gain_reg           <= htlc_pkg::RST_SMOOTH_GAIN;
            open_angle_reg     <= htlc_pkg::RST_OPEN_ANGLE;
            closed_angle_reg   <= htlc_pkg::RST_CLOSED_ANGLE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                htlc_pkg::REG_HALL_THRESHOLD:
                    hall_threshold_reg <= cfg_data[htlc_pkg::THRESH_W-1:0];
                htlc_pkg::REG_CLOSE_DELAY:
                    close_delay_reg <= cfg_data[htlc_pkg::DELAY_W-1:0];
                htlc_pkg::REG_OPEN_DELAY:
                    open_delay_reg <= cfg_data[htlc_pkg::DELAY_W-1:0];
                htlc_pkg::REG_SMOOTH_GAIN:
                    gain_reg <= cfg_data[GAIN_W-1:0];
                htlc_pkg::REG_OPEN_ANGLE:
                    open_angle_reg <= cfg_data[ANGLE_W-1:0];
                htlc_pkg::REG_CLOSED_ANGLE:
                    closed_angle_reg <= cfg_data[ANGLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_item.tick    = mode;
    assign in_item.time_ms = time_ms;

    htlc_ring #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .in_sample   (sample),
        .out_valid   (ring_valid),
        .out_ready   (ring_ready),
        .out_item    (ring_item),
        .out_average (ring_avg)
    );

    // stage handshakes: a stage takes a word when empty or emptying
    assign f_ready    = !out_valid_reg || out_ready;
    assign e_ready    = !e_valid_reg || f_ready;
    assign ring_ready = e_ready;
    assign e_load     = ring_valid && e_ready;
    assign f_load     = e_valid_reg && f_ready;

    // contact latch and lever timing; the state regs always hold the values
    // after the last word that left the ring
    assign at_contact = 32'(ring_avg) >= 32'(hall_threshold_reg);

    always_comb
    begin
        latch_next   = latch_reg;
        contact_next = contact_reg;
        target_next  = target_reg;
        if (at_contact && !latch_reg)
        begin
            contact_next = ring_item.time_ms;
            latch_next   = 1'b1;
        end
        elapsed = ring_item.time_ms - contact_next;
        if (latch_next)
        begin
            if (elapsed >= TIME_W'(close_delay_reg)
                && elapsed < TIME_W'(open_delay_reg))
            begin
                target_next = closed_angle_reg;
            end
            else if (elapsed >= TIME_W'(open_delay_reg))
            begin
                target_next = open_angle_reg;
                if (!at_contact)
                begin
                    latch_next = 1'b0;
                end
            end
        end
    end

    // first-order filter: pos + g * (target - pos), rounded half up
    assign gain_eff = (gain_reg > htlc_pkg::Q16_ONE) ? htlc_pkg::Q16_ONE : gain_reg;
    assign pos_diff = $signed({1'b0, target_reg, {FRAC_W{1'b0}}})
                    - $signed({1'b0, position_reg});
    assign filt_acc = $signed({{(ACC_W - POS_W - FRAC_W){1'b0}}, position_reg,
                               {FRAC_W{1'b0}}})
                    + ACC_W'(pos_diff * $signed({1'b0, gain_eff}))
                    + HALF_LSB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            latch_reg     <= 1'b0;
            contact_reg   <= '0;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
        end
        else
        begin
            if (e_ready)
            begin
                e_valid_reg <= ring_valid;
            end
            if (e_load && ring_item.tick)
            begin
                latch_reg   <= latch_next;
                contact_reg <= contact_next;
                target_reg  <= target_next;
            end
            if (f_ready)
            begin
                out_valid_reg <= e_valid_reg;
            end
            if (f_load && e_tick_reg)
            begin
                position_reg <= filt_acc[FRAC_W +: POS_W];
            end
        end
    end

    // word payload through the tick and output stages
    always_ff @(posedge clk)
    begin
        if (e_load)
        begin
            e_tick_reg <= ring_item.tick;
            e_avg_reg  <= ring_avg;
        end
        if (f_load)
        begin
            out_avg_reg     <= e_avg_reg;
            out_latched_reg <= latch_reg;
            out_target_reg  <= target_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_level = out_avg_reg;
    assign latched       = out_latched_reg;
    assign target_angle  = out_target_reg;
    assign position_q16  = position_reg;
    assign servo_angle   = position_reg[FRAC_W +: ANGLE_W];

    a_latch_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(latch_reg) |-> $past(e_load && ring_item.tick))
        else $error("latch set without a tick entering the tick stage");

    a_lever_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(e_load && ring_item.tick) |=> $stable(target_reg) && $stable(contact_reg))
        else $error("lever state moved without a tick");

    a_position_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(f_load && e_tick_reg) |=> $stable(position_reg))
        else $error("servo position moved without a tick");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty output register");

endmodule
